@@ rtl/mnts_pkg.sv @@
// Shared types, constants and elaboration-time tables for the MIDI note tone synth.
// Holds the sine ROM contents and the per-note phase step table; no dependencies.
package mnts_pkg;

  localparam int SAMPLE_RATE = 48000;
  localparam int PHASE_BITS  = 24;
  localparam int SINE_DEPTH  = 1024;
  localparam int SINE_AW     = $clog2(SINE_DEPTH);

  localparam int NOTE_W   = 7;
  localparam int LEN_W    = 20;
  localparam int AMP_W    = 16;
  localparam int FADE_W   = 13;
  localparam int SAMPLE_W = 16;
  localparam int ENV_FRAC = 16;
  localparam int ENV_W    = ENV_FRAC + 1;
  localparam int GAIN_W   = 16;
  localparam int WAVE_W   = 32;
  localparam int PROD_W   = 48;
  localparam int MAG_W    = 17;

  localparam int NOTE_COUNT = 1 << NOTE_W;
  localparam int SEMITONES  = 12;

  localparam int DIV_BITS_PER_CYCLE = 4;
  localparam int DIV_CYCLES         = ENV_FRAC / DIV_BITS_PER_CYCLE;
  localparam int DIV_CNT_W          = $clog2(DIV_CYCLES);

  localparam int IN_TDATA_W  = ((NOTE_W + LEN_W + AMP_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((SAMPLE_W + 7) / 8) * 8;

  localparam logic [FADE_W-1:0] FADE_RESET = FADE_W'(480);

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  localparam int ROUND_SHIFT = 31;

  localparam logic [63:0] Q30_ONE     = 64'h4000_0000;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] STEP_DEN    = 64'(SAMPLE_RATE) * 64'd100000;

  localparam logic signed [15:0] MIX_FUND = 16'sd27853;
  localparam logic signed [15:0] MIX_HARM = 16'sd4915;

  localparam logic [63:0] TOP_OCTAVE_E5 [SEMITONES] = '{
    64'd664487516,  64'd704000000,  64'd745862018,  64'd790213282,
    64'd837201809,  64'd886984419,  64'd939727257,  64'd995606348,
    64'd1054808182, 64'd1117530341, 64'd1183982153, 64'd1254385395
  };

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef sample_t sine_rom_t [SINE_DEPTH];
  typedef logic [PHASE_BITS-1:0] step_tbl_t [NOTE_COUNT];

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FUND,
    ST_HARM,
    ST_DIVW,
    ST_GAIN,
    ST_MUL,
    ST_OUT
  } ctl_state_t;

  typedef enum logic [1:0] {
    ENV_ZERO,
    ENV_FULL,
    ENV_DIV
  } env_mode_t;

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] w;
    logic [63:0] quad;
    logic [63:0] rem;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      w    = 64'(4 * k);
      quad = w / SINE_DEPTH;
      rem  = w % SINE_DEPTH;
      if (quad[0]) begin
        rem = 64'(SINE_DEPTH) - rem;
      end
      x  = (HALF_PI_Q30 * rem) / SINE_DEPTH;
      x2 = (x * x) >> 30;
      t  = Q30_ONE - x2 / 110;
      t  = Q30_ONE - ((x2 * t) >> 30) / 72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 6;
      s  = (x * t) >> 30;
      if (s > Q30_ONE) begin
        s = Q30_ONE;
      end
      s = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
      rom[k] = (quad >= 64'd2) ? -sample_t'(s) : sample_t'(s);
    end
    return rom;
  endfunction

  function automatic step_tbl_t build_step_table();
    step_tbl_t   tbl;
    int          d;
    int          oct;
    int          r;
    logic [63:0] num;
    for (int n = 0; n < NOTE_COUNT; n++) begin
      if (n == 0) begin
        tbl[n] = '0;
      end else begin
        d      = NOTE_COUNT - 1 - n;
        oct    = d / SEMITONES;
        r      = d % SEMITONES;
        num    = TOP_OCTAVE_E5[SEMITONES - 1 - r] << (PHASE_BITS - oct);
        tbl[n] = PHASE_BITS'((num + STEP_DEN / 2) / STEP_DEN);
      end
    end
    return tbl;
  endfunction

  localparam sine_rom_t SINE_ROM   = build_sine_rom();
  localparam step_tbl_t STEP_TABLE = build_step_table();

endpackage

@@ rtl/mnts_sine_rom.sv @@
// Synchronous sine ROM, one read per cycle, registered data.
// Depends on mnts_pkg for the table contents and sample type.
module mnts_sine_rom (
  input  logic                        clk,
  input  logic [mnts_pkg::SINE_AW-1:0] addr,
  output mnts_pkg::sample_t           q
);
  import mnts_pkg::*;

  sample_t q_r;

  always_ff @(posedge clk) begin
    q_r <= SINE_ROM[addr];
  end

  assign q = q_r;

endmodule

@@ rtl/mnts_env_div.sv @@
// Iterative restoring divider for the fade envelope: (num << 16) / den, num < den.
// Retires four quotient bits per cycle. Depends on mnts_pkg.
module mnts_env_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [mnts_pkg::FADE_W-1:0]  num,
  input  logic [mnts_pkg::FADE_W-1:0]  den,
  output logic                         done,
  output logic [mnts_pkg::ENV_FRAC-1:0] quot
);
  import mnts_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [FADE_W-1:0]    rem_r;
  logic [FADE_W-1:0]    den_r;
  logic [ENV_FRAC-1:0]  quot_r;
  logic [FADE_W-1:0]    rem_nxt;
  logic [ENV_FRAC-1:0]  quot_nxt;

  always_comb begin
    logic [FADE_W:0] trial;
    logic            qbit;
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    for (int j = 0; j < DIV_BITS_PER_CYCLE; j++) begin
      trial = {rem_nxt, 1'b0};
      qbit  = (trial >= {1'b0, den_r});
      if (qbit) begin
        trial = trial - {1'b0, den_r};
      end
      rem_nxt  = trial[FADE_W-1:0];
      quot_nxt = {quot_nxt[ENV_FRAC-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= num;
      den_r  <= den;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quot_r <= quot_nxt;
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

@@ rtl/midi_note_tone_synth_top.sv @@
// Top level of the MIDI note tone synth: note state, sequencer and sample datapath.
// Depends on mnts_pkg, mnts_sine_rom and mnts_env_div.
//
// Usage: the input stream carries one word per event. in_tuser selects the kind:
// a start word (in_tuser 0) loads note number, length and amplitude and resets
// phase and sample count; a tick word (in_tuser 1) requests the next sample.
// Each tick of an active note yields one output word: a signed Q1.15 sample in
// out_tdata, with out_tlast high on the last sample of the note. Ticks while no
// note is active, and all start words, produce nothing.
// A start word is applied at the edge on which it is accepted. A tick passes from
// acceptance to out_tvalid through the envelope divider and its done flag, the
// gain and product stages and the output register; the two sine ROM reads
// overlap the divider. in_tready returns the cycle after the result is loaded, so
// no new word is accepted while a tick is still in flight.
// cfg_wr_en writes the fade length, to be done only while the block is idle.
// Reset: rst_n (synchronous, low) clears all note state, sets fade length to 480
// and leaves no note active. When the receiver stalls, the finished sample holds
// in the output register while the next word is accepted; a further sample
// waits in the last step until the output register is free.
module midi_note_tone_synth_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // note_number [6:0], length_samples [26:7], amplitude [42:27], zero fill above
  input  logic [mnts_pkg::IN_TDATA_W-1:0]  in_tdata,
  // kind [0]
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // sample_value [15:0]
  output logic [mnts_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tlast,
  input  logic                             cfg_wr_en,
  input  logic [mnts_pkg::FADE_W-1:0]      cfg_wr_data
);
  import mnts_pkg::*;

  ctl_state_t state_r;
  ctl_state_t state_nxt;

  logic [PHASE_BITS-1:0] phase_r;
  logic [LEN_W-1:0]      index_r;
  logic [LEN_W-1:0]      total_r;
  logic [NOTE_W-1:0]     note_r;
  logic [AMP_W-1:0]      amp_r;
  logic                  active_r;
  logic [FADE_W-1:0]     fade_r;

  env_mode_t                  env_mode_r;
  logic signed [WAVE_W-1:0]   fund_r;
  logic signed [WAVE_W-1:0]   wave_r;
  logic [GAIN_W-1:0]          gain_r;
  logic signed [PROD_W-1:0]   prod_r;

  logic                   out_valid_r;
  logic [SAMPLE_W-1:0]    out_data_r;
  logic                   out_last_r;

  logic [NOTE_W-1:0] in_note;
  logic [LEN_W-1:0]  in_len;
  logic [AMP_W-1:0]  in_amp;
  logic              in_acc;
  logic              tick_go;
  logic              out_free;
  logic              out_load;
  logic              rom_harm;
  logic              div_start;
  logic              div_done;
  logic [ENV_FRAC-1:0] div_quot;
  sample_t           rom_q;
  logic [SINE_AW-1:0] rom_addr;

  logic [FADE_W-1:0] fade_eff;
  logic              env_rise;
  logic              env_fall;
  logic [LEN_W-1:0]  env_num;
  env_mode_t         env_mode;
  logic [ENV_W-1:0]  env_val;

  logic [PROD_W-1:0] prod_abs;
  logic [MAG_W-1:0]  prod_mag;
  logic [SAMPLE_W-1:0] sample_res;
  logic              last_res;

  assign in_note = in_tdata[NOTE_W-1:0];
  assign in_len  = in_tdata[NOTE_W+LEN_W-1:NOTE_W];
  assign in_amp  = in_tdata[NOTE_W+LEN_W+AMP_W-1:NOTE_W+LEN_W];

  assign in_acc   = in_tvalid & in_tready;
  assign tick_go  = in_acc & (in_tuser == KIND_TICK) & active_r;
  assign out_free = ~out_valid_r | out_tready;

  // envelope numerator and mode from the current sample position
  always_comb begin
    fade_eff = (fade_r == '0) ? FADE_W'(1) : fade_r;
    env_rise = (index_r < LEN_W'(fade_eff));
    env_fall = ({1'b0, index_r} + (LEN_W + 1)'(fade_eff)) > {1'b0, total_r};
    if (env_fall) begin
      env_num = total_r - index_r;
    end else if (env_rise) begin
      env_num = index_r;
    end else begin
      env_num = LEN_W'(fade_eff);
    end
    if (env_num == '0) begin
      env_mode = ENV_ZERO;
    end else if (env_num >= LEN_W'(fade_eff)) begin
      env_mode = ENV_FULL;
    end else begin
      env_mode = ENV_DIV;
    end
  end

  always_comb begin
    case (env_mode_r)
      ENV_ZERO: env_val = '0;
      ENV_FULL: env_val = ENV_W'(1) << ENV_FRAC;
      ENV_DIV:  env_val = {1'b0, div_quot};
      default:  env_val = '0;
    endcase
  end

  // round half away from zero, then saturate
  always_comb begin
    prod_abs = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);
    prod_mag = MAG_W'((prod_abs + (PROD_W'(1) << (ROUND_SHIFT - 1))) >> ROUND_SHIFT);
    if (note_r == '0) begin
      sample_res = '0;
    end else if (prod_r[PROD_W-1]) begin
      sample_res = (prod_mag > MAG_W'(32768)) ? SAMPLE_W'(16'sh8000)
                                               : SAMPLE_W'(-prod_mag);
    end else begin
      sample_res = (prod_mag > MAG_W'(32767)) ? SAMPLE_W'(16'sh7FFF)
                                               : SAMPLE_W'(prod_mag);
    end
    last_res = ({1'b0, index_r} + (LEN_W + 1)'(1)) >= {1'b0, total_r};
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (tick_go) state_nxt = ST_FUND;
      ST_FUND: state_nxt = ST_HARM;
      ST_HARM: state_nxt = ST_DIVW;
      ST_DIVW: if (div_done) state_nxt = ST_GAIN;
      ST_GAIN: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    rom_harm  = 1'b1;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        rom_harm  = 1'b0;
      end
      ST_OUT:  out_load = out_free;
      default: ;
    endcase
    div_start = tick_go;
  end

  assign rom_addr = rom_harm ? phase_r[PHASE_BITS-2 -: SINE_AW]
                             : phase_r[PHASE_BITS-1 -: SINE_AW];

  mnts_sine_rom u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .q    (rom_q)
  );

  mnts_env_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (env_num[FADE_W-1:0]),
    .den   (fade_eff),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= '0;
      index_r     <= '0;
      total_r     <= '0;
      note_r      <= '0;
      amp_r       <= '0;
      active_r    <= 1'b0;
      fade_r      <= FADE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        fade_r <= cfg_wr_data;
      end
      if (in_acc && (in_tuser == KIND_START)) begin
        note_r   <= in_note;
        total_r  <= in_len;
        amp_r    <= in_amp;
        phase_r  <= '0;
        index_r  <= '0;
        active_r <= (in_len != '0);
      end
      if (out_load) begin
        phase_r <= phase_r + STEP_TABLE[note_r];
        index_r <= index_r + 1'b1;
        if (last_res) begin
          active_r <= 1'b0;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_go) begin
      env_mode_r <= env_mode;
    end
    if (state_r == ST_FUND) begin
      fund_r <= WAVE_W'(rom_q) * WAVE_W'(MIX_FUND);
    end
    if (state_r == ST_HARM) begin
      wave_r <= fund_r + WAVE_W'(rom_q) * WAVE_W'(MIX_HARM);
    end
    if (state_r == ST_GAIN) begin
      gain_r <= GAIN_W'(((AMP_W + ENV_W)'(amp_r) * (AMP_W + ENV_W)'(env_val)
                + ((AMP_W + ENV_W)'(1) << (ENV_FRAC - 1))) >> ENV_FRAC);
    end
    if (state_r == ST_MUL) begin
      prod_r <= PROD_W'(wave_r) * PROD_W'($signed({1'b0, gain_r}));
    end
    if (out_load) begin
      out_data_r <= sample_res;
      out_last_r <= last_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_data_r);
  assign out_tlast  = out_last_r;

endmodule

@@ tb/tone_sample_checker.sv @@
// Checker for the MIDI note tone synth: watches the word, sample and fade-length ports,
// predicts every sample from its own model of the note state and compares them in order.
// Depends on mnts_pkg for widths and word kinds.
module tone_sample_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [mnts_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [mnts_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             out_tlast,
  input  logic                             cfg_wr_en,
  input  logic [mnts_pkg::FADE_W-1:0]      cfg_wr_data,
  output int                               fail_count,
  output int                               pending,
  output int                               samples_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import mnts_pkg::*;

  localparam longint unsigned UNITY_Q30   = 64'd1 << 30;
  localparam longint unsigned QUARTER_RAD = 64'd1686629713;
  localparam longint unsigned RATE_E5     = 64'(SAMPLE_RATE) * 64'd100000;
  localparam longint          FUND_WEIGHT = 27853;
  localparam longint          HARM_WEIGHT = 4915;
  localparam int              REPORT_MAX  = 10;

  localparam longint unsigned OCTAVE_FREQ_E5 [12] = '{
    64'd664487516,  64'd704000000,  64'd745862018,  64'd790213282,
    64'd837201809,  64'd886984419,  64'd939727257,  64'd995606348,
    64'd1054808182, 64'd1117530341, 64'd1183982153, 64'd1254385395
  };

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       last;
  } tone_sample_t;

  tone_sample_t expected_samples [$];

  logic [PHASE_BITS-1:0] phase;
  logic [LEN_W-1:0]      sample_idx;
  logic [LEN_W-1:0]      note_len;
  logic [NOTE_W-1:0]     note;
  logic [AMP_W-1:0]      level;
  logic                  playing;
  logic [FADE_W-1:0]     fade_len;
  int                    fails = 0;
  int                    samples = 0;

  function automatic longint sine_q15(logic [SINE_AW-1:0] k);
    longint unsigned w, quad, rem, x, x2, t, s;
    w    = 64'(k) << 2;
    quad = w / SINE_DEPTH;
    rem  = w % SINE_DEPTH;
    if (quad[0]) begin
      rem = SINE_DEPTH - rem;
    end
    x  = (QUARTER_RAD * rem) / SINE_DEPTH;
    x2 = (x * x) >> 30;
    t  = UNITY_Q30 - x2 / 110;
    t  = UNITY_Q30 - ((x2 * t) >> 30) / 72;
    t  = UNITY_Q30 - ((x2 * t) >> 30) / 42;
    t  = UNITY_Q30 - ((x2 * t) >> 30) / 20;
    t  = UNITY_Q30 - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    if (s > UNITY_Q30) begin
      s = UNITY_Q30;
    end
    s = (s * 64'd32767 + (UNITY_Q30 >> 1)) >> 30;
    return (quad >= 2) ? -longint'(s) : longint'(s);
  endfunction

  function automatic logic [PHASE_BITS-1:0] phase_step(logic [NOTE_W-1:0] n);
    int              d, oct, r;
    longint unsigned num;
    if (n == 0) begin
      return '0;
    end
    d   = 127 - int'(n);
    oct = d / 12;
    r   = d % 12;
    num = OCTAVE_FREQ_E5[11 - r] << (PHASE_BITS - oct);
    return PHASE_BITS'((num + RATE_E5 / 2) / RATE_E5);
  endfunction

  function automatic longint fade_gain_q16(longint i, longint total);
    longint f, num;
    f   = (fade_len == 0) ? 1 : longint'(fade_len);
    num = f;
    if (i < f) begin
      num = i;
    end
    if (i > total - f) begin
      num = total - i;
    end
    if (num <= 0) begin
      return 0;
    end
    if (num >= f) begin
      return 65536;
    end
    return (num <<< 16) / f;
  endfunction

  task automatic apply_word(logic kind, logic [IN_TDATA_W-1:0] word);
    tone_sample_t s;
    longint       wave, gain, v, mag, res;
    if (kind == KIND_START) begin
      note       = word[NOTE_W-1:0];
      note_len   = word[NOTE_W +: LEN_W];
      level      = word[NOTE_W+LEN_W +: AMP_W];
      phase      = '0;
      sample_idx = '0;
      playing    = (note_len != 0);
    end else if (playing) begin
      res = 0;
      if (note != 0) begin
        wave = FUND_WEIGHT * sine_q15(phase[PHASE_BITS-1 -: SINE_AW]) +
               HARM_WEIGHT * sine_q15(phase[PHASE_BITS-2 -: SINE_AW]);
        gain = (longint'(level) *
                fade_gain_q16(longint'(sample_idx), longint'(note_len)) + 32768) >>> 16;
        v    = wave * gain;
        mag  = (v < 0) ? -v : v;
        mag  = (mag + (64'sd1 <<< 30)) >>> 31;
        if (v < 0) begin
          res = (mag > 32768) ? -32768 : -mag;
        end else begin
          res = (mag > 32767) ? 32767 : mag;
        end
      end
      s.value = SAMPLE_W'(res);
      s.last  = (longint'(sample_idx) + 1 >= longint'(note_len));
      expected_samples = {expected_samples, s};
      phase      = phase + phase_step(note);
      sample_idx = sample_idx + 1'b1;
      if (s.last) begin
        playing = 1'b0;
      end
    end
  endtask

  task automatic check_sample(logic [SAMPLE_W-1:0] got, logic got_last);
    tone_sample_t want;
    if (expected_samples.size() == 0) begin
      fails++;
      if (fails <= REPORT_MAX) begin
        $display("unexpected sample %0d last %0b at %0t", $signed(got), got_last, $realtime);
      end
    end else begin
      want = expected_samples.pop_front();
      samples++;
      if (got !== want.value || got_last !== want.last) begin
        fails++;
        if (fails <= REPORT_MAX) begin
          $display("sample mismatch at %0t: expected %0d last %0b, got %0d last %0b",
                   $realtime, want.value, want.last, $signed(got), got_last);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      phase      = '0;
      sample_idx = '0;
      note_len   = '0;
      note       = '0;
      level      = '0;
      playing    = 1'b0;
      fade_len   = FADE_RESET;
      expected_samples.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        check_sample(out_tdata[SAMPLE_W-1:0], out_tlast);
      end
      if (cfg_wr_en) begin
        fade_len = cfg_wr_data;
      end
      if (in_tvalid && in_tready) begin
        apply_word(in_tuser, in_tdata);
      end
    end
    fail_count      <= fails;
    pending         <= expected_samples.size();
    samples_checked <= samples;
  end

endmodule

@@ tb/tb.sv @@
// Top of the MIDI note tone synth testbench: clock, reset, note and tick stimulus,
// output back-pressure, fade-length writes and the verdict.
// Depends on mnts_pkg, midi_note_tone_synth_top and tone_sample_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mnts_pkg::*;

  localparam int STALL_LIMIT     = 5000;
  localparam int PRESSURE_CYCLES = 400;
  localparam int PRESSURE_AFTER  = 200;
  localparam int WORD_TARGET     = 550;
  localparam int SETTLE_CYCLES   = 20;
  localparam int DRAIN_CYCLES    = 30;
  localparam int PLAN_LEN        = 8;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_wr_en;
  logic [FADE_W-1:0]      cfg_wr_data;

  int fail_count;
  int pending;
  int samples_checked;
  int words_sent = 0;
  int fade_writes = 0;
  bit steady_send = 1'b0;
  bit pressure_done = 1'b0;

  midi_note_tone_synth_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  tone_sample_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tlast       (out_tlast),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .fail_count      (fail_count),
    .pending         (pending),
    .samples_checked (samples_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 60);
  endfunction

  task automatic send_word(logic kind, logic [NOTE_W-1:0] n, logic [LEN_W-1:0] len,
                           logic [AMP_W-1:0] amp);
    int gap;
    gap = steady_send ? 0 : pause_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {{(IN_TDATA_W-NOTE_W-LEN_W-AMP_W){1'b0}}, amp, len, n};
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  task automatic play_note(logic [NOTE_W-1:0] n, logic [LEN_W-1:0] len,
                           logic [AMP_W-1:0] amp, int ticks);
    steady_send = ($urandom_range(0, 3) == 0);
    send_word(KIND_START, n, len, amp);
    repeat (ticks) send_word(KIND_TICK, NOTE_W'($urandom), LEN_W'($urandom), AMP_W'($urandom));
  endtask

  task automatic set_fade(int value);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= FADE_W'(value);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    fade_writes++;
  endtask

  task automatic random_step();
    logic [NOTE_W-1:0] n;
    logic [LEN_W-1:0]  len;
    logic [AMP_W-1:0]  amp;
    int                ticks;
    int                r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      steady_send = 1'b0;
      send_word(1'($urandom), NOTE_W'($urandom), LEN_W'($urandom), AMP_W'($urandom));
      return;
    end
    n = (r < 18) ? '0 : NOTE_W'($urandom_range(1, 127));
    r = $urandom_range(0, 99);
    amp = (r < 10) ? '1 : (r < 15) ? '0 : AMP_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 5) begin
      len   = '0;
      ticks = $urandom_range(0, 2);
    end else if (r < 11) begin
      len   = {1'b1, 19'($urandom)};
      ticks = $urandom_range(1, 4);
    end else begin
      len   = LEN_W'($urandom_range(1, 30));
      r     = $urandom_range(0, 99);
      ticks = (r < 70) ? int'(len) :
              (r < 85) ? int'(len) + $urandom_range(1, 3) : $urandom_range(0, int'(len) - 1);
    end
    play_note(n, len, amp, ticks);
  endtask

  initial begin
    int out_gap;
    out_tready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (!pressure_done && words_sent >= PRESSURE_AFTER) begin
        pressure_done = 1'b1;
        out_tready <= 1'b0;
        repeat (PRESSURE_CYCLES) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      out_gap = pause_len();
      if (out_gap > 0) begin
        out_tready <= 1'b0;
        repeat (out_gap) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst_n && !(in_tvalid && in_tready) && !(out_tvalid && out_tready)) begin
        quiet++;
      end else begin
        quiet = 0;
      end
    end
    $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int fade_plan [PLAN_LEN];
    int phase_end;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tuser    <= KIND_START;
    in_tdata    <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    fade_plan = '{0, 2, 8191, 4800, $urandom_range(3, 16), $urandom_range(1, 4800), 480, 1};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    play_note(7'd69, 20'd4, 16'hFFFF, 5);
    play_note(7'd0, 20'd3, 16'h8000, 3);
    play_note(7'd60, 20'd0, 16'h1234, 1);
    play_note(7'd127, 20'hFFFFF, 16'hFFFF, 2);
    play_note(7'd1, 20'd2, 16'h0001, 2);
    set_fade(1);
    play_note(7'd100, 20'd5, 16'hFFFF, 5);

    for (int p = 0; p < PLAN_LEN; p++) begin
      set_fade(fade_plan[p]);
      phase_end = words_sent + (WORD_TARGET - words_sent) / (PLAN_LEN - p);
      while (words_sent < phase_end) random_step();
    end

    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d input words and %0d checked samples over %0d fade-length writes",
             words_sent, samples_checked, fade_writes);
    $display("notes included silence, zero length, aborts, idle ticks and a long output stall");
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
